>>> hdl/hwd_pkg.sv
// ----------------------------------------------------------------------------
// hwd_pkg
// Shared types and constants for the Huffman tree-walk decoder.
// ----------------------------------------------------------------------------
package hwd_pkg;

  localparam int TREE_NODES_DEF = 512;
  localparam int NODE_W = 9;
  localparam int SYM_W = 8;
  localparam int TOTAL_W = 32;
  localparam int BYTE_W = 8;
  localparam int BITCNT_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam logic [NODE_W-1:0] NO_CHILD = '1;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_DECODE  = 2'd1,
    MODE_RESTART = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT  = 2'd0,
    CFG_TOTAL = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } walk_state_t;

  typedef struct packed {
    logic              leaf;
    logic [SYM_W-1:0]  symbol;
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
  } node_entry_t;

  localparam int ENTRY_W = $bits(node_entry_t);

  typedef struct packed {
    logic             valid;
    logic             flush;
    logic [SYM_W-1:0] symbol;
    logic             status;
    logic             finished;
  } result_ev_t;

endpackage

>>> hdl/hwd_node_ram.sv
// ----------------------------------------------------------------------------
// hwd_node_ram
// Node table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hwd_node_ram
  import hwd_pkg::*;
#(
  parameter int TREE_NODES = TREE_NODES_DEF,
  localparam int AW = $clog2(TREE_NODES)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  node_entry_t        wdata,
  input  logic [AW-1:0]      raddr,
  output node_entry_t        rdata
);

  node_entry_t mem [TREE_NODES];
  node_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/hwd_walk_ctrl.sv
// ----------------------------------------------------------------------------
// hwd_walk_ctrl
// Bit-serial tree walk: shifts the data byte out one bit per cycle save a root
// re-read per leaf; follows a child per bit; an event per leaf or missing child.
// ----------------------------------------------------------------------------
module hwd_walk_ctrl
  import hwd_pkg::*;
#(
  parameter int TREE_NODES = TREE_NODES_DEF,
  localparam int AW = $clog2(TREE_NODES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_mode,
  input  logic [NODE_W-1:0]    in_node_index,
  input  logic                 in_node_is_leaf,
  input  logic [SYM_W-1:0]     in_node_symbol,
  input  logic [NODE_W-1:0]    in_left_child,
  input  logic [NODE_W-1:0]    in_right_child,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TOTAL_W-1:0]   cfg_wdata,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output node_entry_t          mem_wdata,
  output logic [AW-1:0]        mem_raddr,
  input  node_entry_t          mem_rdata,
  output result_ev_t           ev
);

  walk_state_t         state_r, state_nxt;
  logic [NODE_W-1:0]   cur_r, cur_nxt;
  logic                arrived_r, arrived_nxt;
  logic [BYTE_W-1:0]   bits_r, bits_nxt;
  logic [BITCNT_W-1:0] left_r, left_nxt;
  logic [TOTAL_W-1:0]  count_r, count_nxt;
  logic                halted_r, halted_nxt;
  logic [NODE_W-1:0]   root_r, root_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;

  logic [TOTAL_W-1:0]  count_inc;
  logic                fin_inc;
  logic                cur_ok;
  logic [NODE_W-1:0]   child;
  logic                child_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cur_r     <= '0;
      arrived_r <= 1'b0;
      left_r    <= '0;
      count_r   <= '0;
      halted_r  <= 1'b0;
      root_r    <= '0;
      total_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      cur_r     <= cur_nxt;
      arrived_r <= arrived_nxt;
      left_r    <= left_nxt;
      count_r   <= count_nxt;
      halted_r  <= halted_nxt;
      root_r    <= root_nxt;
      total_r   <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
  end

  assign count_inc = count_r + TOTAL_W'(1);
  assign fin_inc   = (count_inc >= total_r);
  assign cur_ok    = (32'(cur_r) < TREE_NODES);
  assign child     = !cur_ok ? NO_CHILD :
                     (bits_r[BYTE_W-1] ? mem_rdata.right : mem_rdata.left);
  assign child_ok  = (child != NO_CHILD) && (32'(child) < TREE_NODES);

  assign mem_waddr = AW'(in_node_index);
  assign mem_wdata = '{leaf: in_node_is_leaf, symbol: in_node_symbol,
                       left: in_left_child, right: in_right_child};
  assign busy      = (state_r != ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    arrived_nxt = arrived_r;
    bits_nxt    = bits_r;
    left_nxt    = left_r;
    count_nxt   = count_r;
    halted_nxt  = halted_r;
    root_nxt    = root_r;
    total_nxt   = total_r;
    mem_we      = 1'b0;
    mem_raddr   = AW'(cur_r);
    ev          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (mode_t'(in_mode))
            MODE_LOAD: begin
              mem_we = (32'(in_node_index) < TREE_NODES);
            end
            MODE_DECODE: begin
              if (!halted_r && (count_r < total_r)) begin
                bits_nxt    = in_data_byte;
                left_nxt    = BITCNT_W'(BYTE_W);
                arrived_nxt = 1'b0;
                state_nxt   = ST_WALK;
              end
            end
            MODE_RESTART: begin
              cur_nxt    = root_r;
              count_nxt  = '0;
              halted_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (arrived_r && mem_rdata.leaf) begin
          ev.valid    = 1'b1;
          ev.symbol   = mem_rdata.symbol;
          ev.finished = fin_inc;
          count_nxt   = count_inc;
          cur_nxt     = root_r;
          arrived_nxt = 1'b0;
          mem_raddr   = AW'(root_r);
          if (fin_inc || (left_r == '0)) begin
            state_nxt = ST_FLUSH;
          end
        end else if (left_r == '0) begin
          state_nxt = ST_FLUSH;
        end else if (!child_ok) begin
          ev.valid    = 1'b1;
          ev.status   = 1'b1;
          ev.finished = (count_r >= total_r);
          halted_nxt  = 1'b1;
          state_nxt   = ST_FLUSH;
        end else begin
          cur_nxt     = child;
          arrived_nxt = 1'b1;
          mem_raddr   = AW'(child);
          bits_nxt    = {bits_r[BYTE_W-2:0], 1'b0};
          left_nxt    = left_r - BITCNT_W'(1);
        end
      end
      ST_FLUSH: begin
        ev.flush  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ROOT: begin
          root_nxt = cfg_wdata[NODE_W-1:0];
          cur_nxt  = cfg_wdata[NODE_W-1:0];
        end
        CFG_TOTAL: total_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/hwd_out_stage.sv
// ----------------------------------------------------------------------------
// hwd_out_stage
// Holds back one result so that the final word of a byte carries last.
// ----------------------------------------------------------------------------
module hwd_out_stage
  import hwd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  result_ev_t       ev,
  output logic             out_valid,
  output logic [SYM_W-1:0] out_symbol,
  output logic             out_status,
  output logic             out_finished,
  output logic             out_last
);

  logic             pend_v_r, pend_v_nxt;
  logic [SYM_W-1:0] pend_sym_r;
  logic             pend_st_r;
  logic             pend_fin_r;
  logic             out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_symbol_r;
  logic             out_status_r;
  logic             out_finished_r;
  logic             out_last_r;

  assign out_valid_nxt = pend_v_r && (ev.valid || ev.flush);
  assign pend_v_nxt    = ev.valid ? 1'b1 : (ev.flush ? 1'b0 : pend_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_symbol_r   <= pend_sym_r;
      out_status_r   <= pend_st_r;
      out_finished_r <= pend_fin_r;
      out_last_r     <= ev.flush;
    end
    if (ev.valid) begin
      pend_sym_r <= ev.symbol;
      pend_st_r  <= ev.status;
      pend_fin_r <= ev.finished;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_symbol   = out_symbol_r;
  assign out_status   = out_status_r;
  assign out_finished = out_finished_r;
  assign out_last     = out_last_r;

endmodule

>>> hdl/huffman_tree_walk_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// Loads a Huffman code tree node by node and decodes compressed bytes by
// walking the tree MSB first, one bit per cycle bar a root re-read per leaf.
// ----------------------------------------------------------------------------
//   channel   handshake          payload
//   input     start / busy       in_mode, in_node_*, in_*_child, in_data_byte
//   result    out_valid strobe   out_symbol, out_status, out_finished, out_last
//   config    cfg_we             cfg_index, cfg_wdata
//
// While a decode byte is walked, busy stays high through one node-table read
// per bit, one root read after each leaf and a flush state that closes the
// byte; when the eighth bit ends on a leaf, the byte closes from that leaf.
// The walk ends early when the total is reached or a child is missing.
// Load, restart and ignored bytes are handled in the accepting cycle only.
// Results trail the walk by one word; the last one follows busy low.
// Reset clears walk state, counters, config registers and valid flags; the node table is not cleared.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder
  import hwd_pkg::*;
#(
  parameter int TREE_NODES = TREE_NODES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_mode,
  input  logic [NODE_W-1:0]    in_node_index,
  input  logic                 in_node_is_leaf,
  input  logic [SYM_W-1:0]     in_node_symbol,
  input  logic [NODE_W-1:0]    in_left_child,
  input  logic [NODE_W-1:0]    in_right_child,
  input  logic [BYTE_W-1:0]    in_data_byte,
  output logic                 out_valid,
  output logic [SYM_W-1:0]     out_symbol,
  output logic                 out_status,
  output logic                 out_finished,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TOTAL_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(TREE_NODES);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  node_entry_t   mem_wdata;
  logic [AW-1:0] mem_raddr;
  node_entry_t   mem_rdata;
  result_ev_t    ev;

  hwd_node_ram #(.TREE_NODES(TREE_NODES)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  hwd_walk_ctrl #(.TREE_NODES(TREE_NODES)) u_walk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_node_index   (in_node_index),
    .in_node_is_leaf (in_node_is_leaf),
    .in_node_symbol  (in_node_symbol),
    .in_left_child   (in_left_child),
    .in_right_child  (in_right_child),
    .in_data_byte    (in_data_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata),
    .ev              (ev)
  );

  hwd_out_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .ev           (ev),
    .out_valid    (out_valid),
    .out_symbol   (out_symbol),
    .out_status   (out_status),
    .out_finished (out_finished),
    .out_last     (out_last)
  );

endmodule
